/* hw/rtl/projector_power_sequencer_top_defines.svh */
// Assertion macros for the projector power sequencer.
// Each macro takes a label, an antecedent, a consequent and a message string.
`ifndef PROJECTOR_POWER_SEQUENCER_TOP_DEFINES_SVH
`define PROJECTOR_POWER_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PPS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PPS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/pps_pkg.sv */
`timescale 1ns / 1ps

package pps_pkg;

  localparam int unsigned TimerWidth = 16;
  localparam int unsigned PeriodWidth = 16;
  localparam int unsigned CmpWidth = (TimerWidth > PeriodWidth) ? TimerWidth : PeriodWidth;

  localparam logic [TimerWidth-1:0] TimerMax = {TimerWidth{1'b1}};

  localparam logic [2:0] ModeStandby  = 3'd0;
  localparam logic [2:0] ModeOn       = 3'd1;
  localparam logic [2:0] ModeGrace    = 3'd2;
  localparam logic [2:0] ModePrecool  = 3'd3;
  localparam logic [2:0] ModeCooling  = 3'd4;
  localparam logic [2:0] ModeShutdown = 3'd5;

  localparam logic [1:0] CmdStop = 2'd0;
  localparam logic [1:0] CmdDown = 2'd1;
  localparam logic [1:0] CmdUp   = 2'd2;

  localparam logic [1:0] RegGrace   = 2'd0;
  localparam logic [1:0] RegPreCool = 2'd1;
  localparam logic [1:0] RegCool    = 2'd2;

  localparam logic [PeriodWidth-1:0] GraceReset   = PeriodWidth'(1000);
  localparam logic [PeriodWidth-1:0] PreCoolReset = PeriodWidth'(1000);
  localparam logic [PeriodWidth-1:0] CoolReset    = PeriodWidth'(5000);

  typedef struct packed {
    logic [2:0]            mode;
    logic [TimerWidth-1:0] elapsed;
    logic                  relay;
  } state_t;

  typedef struct packed {
    logic [PeriodWidth-1:0] grace;
    logic [PeriodWidth-1:0] pre_cool;
    logic [PeriodWidth-1:0] cool;
  } periods_t;

  typedef struct packed {
    logic       relay_on;
    logic       cmd_valid;
    logic [1:0] screen_cmd;
    logic [2:0] mode_code;
  } result_t;

endpackage

/* hw/rtl/pps_step.sv */
`timescale 1ns / 1ps

module pps_step import pps_pkg::*; (
  input  state_t   state_i,
  input  periods_t periods_i,
  input  logic     active_i,
  output state_t   state_o,
  output result_t  result_o
);

  logic [TimerWidth-1:0] elapsed_inc;
  logic [PeriodWidth-1:0] period;
  logic                  expired;
  logic                  cmd_valid;
  logic [1:0]            cmd;

  assign elapsed_inc = (state_i.elapsed == TimerMax) ? state_i.elapsed
                                                     : state_i.elapsed + 1'b1;

  always_comb begin
    unique case (state_i.mode)
      ModeGrace:   period = periods_i.grace;
      ModePrecool: period = periods_i.pre_cool;
      default:     period = periods_i.cool;
    endcase
  end

  assign expired = CmpWidth'(elapsed_inc) >= CmpWidth'(period);

  always_comb begin
    state_o   = state_i;
    cmd_valid = 1'b0;
    cmd       = CmdStop;
    unique case (state_i.mode)
      ModeOn: begin
        if (!active_i) begin
          state_o.elapsed = '0;
          state_o.mode    = ModeGrace;
        end
      end
      ModeGrace: begin
        if (active_i) begin
          state_o.mode = ModeOn;
        end else if (expired) begin
          cmd_valid       = 1'b1;
          cmd             = CmdUp;
          state_o.elapsed = '0;
          state_o.mode    = ModePrecool;
        end else begin
          state_o.elapsed = elapsed_inc;
        end
      end
      ModePrecool: begin
        if (expired) begin
          state_o.elapsed = '0;
          state_o.mode    = ModeCooling;
        end else begin
          state_o.elapsed = elapsed_inc;
        end
      end
      ModeCooling: begin
        if (active_i) begin
          cmd_valid    = 1'b1;
          cmd          = CmdDown;
          state_o.mode = ModeOn;
        end else begin
          state_o.elapsed = elapsed_inc;
          if (expired) begin
            state_o.relay = 1'b0;
            state_o.mode  = ModeShutdown;
          end
        end
      end
      default: begin
        if (active_i) begin
          state_o.relay = 1'b1;
          cmd_valid     = 1'b1;
          cmd           = CmdDown;
          state_o.mode  = ModeOn;
        end
      end
    endcase
  end

  assign result_o.relay_on   = state_o.relay;
  assign result_o.cmd_valid  = cmd_valid;
  assign result_o.screen_cmd = cmd;
  assign result_o.mode_code  = state_o.mode;

endmodule

/* hw/rtl/projector_power_sequencer_top.sv */
`timescale 1ns / 1ps
// Channel  Handshake                 Payload
// in       in_valid_i / in_stall_o   projector_active_i
// out      out_valid_o / out_stall_i relay_on_o, cmd_valid_o, screen_cmd_o, mode_code_o
// cfg      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// On acceptance of a tick item, the mode, timer and relay registers update and
// the result lands in the output register on the same edge.
// A new item is accepted every cycle while the output register is empty or being taken.
// Reset puts the sequencer in standby with the relay on and the periods at defaults.
// A stalled result holds the output register and stalls the input side.
`include "projector_power_sequencer_top_defines.svh"

module projector_power_sequencer_top import pps_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   projector_active_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   relay_on_o,
  output logic                   cmd_valid_o,
  output logic [1:0]             screen_cmd_o,
  output logic [2:0]             mode_code_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [PeriodWidth-1:0] cfg_data_i
);

  state_t   state_q, state_d;
  periods_t periods_q;
  result_t  result_q, result_d;
  logic     out_valid_q;
  logic     accept;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  pps_step u_step (
    .state_i   (state_q),
    .periods_i (periods_q),
    .active_i  (projector_active_i),
    .state_o   (state_d),
    .result_o  (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode    <= ModeStandby;
      state_q.elapsed <= '0;
      state_q.relay   <= 1'b1;
      out_valid_q     <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      periods_q.grace    <= GraceReset;
      periods_q.pre_cool <= PreCoolReset;
      periods_q.cool     <= CoolReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegGrace:   periods_q.grace    <= cfg_data_i;
        RegPreCool: periods_q.pre_cool <= cfg_data_i;
        RegCool:    periods_q.cool     <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign relay_on_o   = result_q.relay_on;
  assign cmd_valid_o  = result_q.cmd_valid;
  assign screen_cmd_o = result_q.screen_cmd;
  assign mode_code_o  = result_q.mode_code;

  `PPS_ASSERT_IMP(a_relay_off_shutdown, state_q.mode != ModeShutdown, state_q.relay, "relay off outside shutdown")
  `PPS_ASSERT_IMP(a_idle_cmd_stop, out_valid_o && !cmd_valid_o, screen_cmd_o == CmdStop, "command code without valid")
  `PPS_ASSERT_IMP(a_up_enters_precool, out_valid_o && cmd_valid_o && screen_cmd_o == CmdUp, mode_code_o == ModePrecool, "screen up outside precool entry")
  `PPS_ASSERT_NXT(a_result_follows_state, accept, mode_code_o == state_q.mode && relay_on_o == state_q.relay, "result does not match updated state")

endmodule

/* tb/sv/projector_power_sequencer_top_tb.sv */
`timescale 1ns / 1ps

module projector_power_sequencer_top_tb;
  import pps_pkg::*;

  localparam logic [1:0] RegUnused = 2'd3;
  localparam int unsigned CycleLimit = 100_000;
  localparam int unsigned RandomTicks = 1250;

  class tick_scoreboard;
    logic [2:0]             mode;
    logic [TimerWidth-1:0]  elapsed;
    logic                   relay;
    logic [PeriodWidth-1:0] grace;
    logic [PeriodWidth-1:0] pre_cool;
    logic [PeriodWidth-1:0] cool;
    result_t                want_q[$];
    int unsigned            mismatches;
    int unsigned            checked;

    function new();
      mode       = ModeStandby;
      elapsed    = '0;
      relay      = 1'b1;
      grace      = GraceReset;
      pre_cool   = PreCoolReset;
      cool       = CoolReset;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_period(logic [1:0] idx, logic [PeriodWidth-1:0] val);
      case (idx)
        RegGrace:   grace = val;
        RegPreCool: pre_cool = val;
        RegCool:    cool = val;
        default: ;
      endcase
    endfunction

    function bit timer_done(logic [PeriodWidth-1:0] period);
      if (elapsed != TimerMax) elapsed = elapsed + 1'b1;
      return CmpWidth'(elapsed) >= CmpWidth'(period);
    endfunction

    function int unsigned pending();
      return want_q.size();
    endfunction

    function void note_tick(logic active);
      result_t want;
      want.cmd_valid  = 1'b0;
      want.screen_cmd = CmdStop;
      case (mode)
        ModeOn: begin
          if (!active) begin
            elapsed = '0;
            mode    = ModeGrace;
          end
        end
        ModeGrace: begin
          if (active) begin
            mode = ModeOn;
          end else if (timer_done(grace)) begin
            want.cmd_valid  = 1'b1;
            want.screen_cmd = CmdUp;
            elapsed         = '0;
            mode            = ModePrecool;
          end
        end
        ModePrecool: begin
          if (timer_done(pre_cool)) begin
            elapsed = '0;
            mode    = ModeCooling;
          end
        end
        ModeCooling: begin
          if (active) begin
            want.cmd_valid  = 1'b1;
            want.screen_cmd = CmdDown;
            mode            = ModeOn;
          end else if (timer_done(cool)) begin
            relay = 1'b0;
            mode  = ModeShutdown;
          end
        end
        default: begin
          if (active) begin
            relay           = 1'b1;
            want.cmd_valid  = 1'b1;
            want.screen_cmd = CmdDown;
            mode            = ModeOn;
          end
        end
      endcase
      want.relay_on  = relay;
      want.mode_code = mode;
      want_q.push_back(want);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (want_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: relay %0b cmd_valid %0b cmd %0d mode %0d",
                   $realtime, got.relay_on, got.cmd_valid, got.screen_cmd, got.mode_code);
        return;
      end
      want = want_q.pop_front();
      checked++;
      if (got.relay_on !== want.relay_on || got.cmd_valid !== want.cmd_valid ||
          got.screen_cmd !== want.screen_cmd || got.mode_code !== want.mode_code) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] result %0d: expected relay %0b cmd_valid %0b cmd %0d mode %0d",
                   $realtime, checked, want.relay_on, want.cmd_valid, want.screen_cmd,
                   want.mode_code);
          $display("    got relay %0b cmd_valid %0b cmd %0d mode %0d",
                   got.relay_on, got.cmd_valid, got.screen_cmd, got.mode_code);
        end
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic                   projector_active_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic                   relay_on_o;
  logic                   cmd_valid_o;
  logic [1:0]             screen_cmd_o;
  logic [2:0]             mode_code_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [1:0]             cfg_index_i;
  logic [PeriodWidth-1:0] cfg_data_i;

  tick_scoreboard sb = new();

  int unsigned cycle_count;
  int unsigned ticks_sent;
  int unsigned settings_used;
  int unsigned burst_left;
  int unsigned gap_max;
  int unsigned hold_request;

  projector_power_sequencer_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .projector_active_i (projector_active_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .relay_on_o         (relay_on_o),
    .cmd_valid_o        (cmd_valid_o),
    .screen_cmd_o       (screen_cmd_o),
    .mode_code_o        (mode_code_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("Timed out after %0d cycles with %0d results outstanding.",
                 cycle_count, sb.pending());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result('{relay_on_o, cmd_valid_o, screen_cmd_o, mode_code_o});
  end

  // The output side switches between randomly chosen stall styles and takes
  // long hold-offs when the stimulus asks for one.
  initial begin
    int unsigned style;
    int unsigned style_left;
    int unsigned hold_left;
    style       = 0;
    style_left  = 0;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (style_left == 0) begin
        style      = $urandom_range(3, 0);
        style_left = $urandom_range(80, 20);
      end
      style_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (style)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(3, 0) == 0);
          2: out_stall_i <= ($urandom_range(9, 0) < 7);
          default: out_stall_i <= (cycle_count % 4 == 0);
        endcase
      end
    end
  end

  task automatic send_tick(logic active);
    if (burst_left == 0) begin
      if (gap_max != 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat ($urandom_range(gap_max, 1) - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(24, 1);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i         <= 1'b1;
    projector_active_i <= active;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_tick(active);
    ticks_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [PeriodWidth-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_period(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_periods(logic [PeriodWidth-1:0] g, logic [PeriodWidth-1:0] p,
                             logic [PeriodWidth-1:0] c);
    drain_results();
    write_reg(RegGrace, g);
    write_reg(RegPreCool, p);
    write_reg(RegCool, c);
    if ($urandom_range(2, 0) == 0) write_reg(RegUnused, PeriodWidth'($urandom));
    settings_used++;
  endtask

  function automatic logic [PeriodWidth-1:0] pick_period();
    if ($urandom_range(5, 0) == 0) return PeriodWidth'($urandom_range(60, 10));
    return PeriodWidth'($urandom_range(9, 0));
  endfunction

  initial begin
    bit [0:3]               warmup;
    bit [0:12]              walk;
    int unsigned            phase;
    int unsigned            n;
    int unsigned            run;
    logic [PeriodWidth-1:0] g;
    logic [PeriodWidth-1:0] p;
    logic [PeriodWidth-1:0] c;

    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    projector_active_i = 1'b0;
    cfg_valid_i        = 1'b0;
    cfg_index_i        = RegGrace;
    cfg_data_i         = '0;
    ticks_sent         = 0;
    settings_used      = 1;
    burst_left         = 0;
    gap_max            = 3;
    hold_request       = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Standby ignores an idle projector, then on and into grace at defaults.
    warmup = 4'b0110;
    foreach (warmup[i]) send_tick(warmup[i]);

    // Short periods with a zero cooling period: back to on from grace, the
    // screen going up, precool ignoring the sense, immediate shutdown, wake
    // from shutdown and a wake during cooling.
    set_periods(16'd2, 16'd1, 16'd0);
    walk = 13'b1000_1000_1000_1;
    foreach (walk[i]) send_tick(walk[i]);

    set_periods(16'd1, 16'd0, 16'd1);
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);
    send_tick(1'b1);

    phase = 0;
    while (ticks_sent < RandomTicks) begin
      g = pick_period();
      p = pick_period();
      c = pick_period();
      set_periods(g, p, c);
      gap_max = $urandom_range(8, 0);
      if (phase == 2) hold_request = 400;
      n = 0;
      while (n < 150) begin
        if ($urandom_range(4, 0) != 0) begin
          run = $urandom_range(4, 1);
          repeat (run) send_tick(1'b1);
          n += run;
          run = $urandom_range(g + p + c + 6, 1);
          repeat (run) send_tick(1'b0);
          n += run;
        end else begin
          run = $urandom_range(8, 1);
          repeat (run) send_tick(1'($urandom));
          n += run;
        end
      end
      phase++;
    end

    // Largest periods: on, then a long idle stretch that stays in grace,
    // then a wake back to on.
    set_periods(16'hFFFF, 16'hFFFF, 16'hFFFF);
    gap_max = 0;
    send_tick(1'b1);
    repeat (200) send_tick(1'b0);
    send_tick(1'b1);

    drain_results();
    repeat (5) @(posedge clk_i);

    $display("Sent %0d ticks under %0d period settings and checked %0d results,",
             ticks_sent, settings_used, sb.checked);
    $display("covering zero, small and largest periods with stalls on both sides.");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing.", sb.mismatches, sb.pending());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
